/* rtl/pde_pkg.sv */
// Shared types and command codes for the polynomial derivative evaluator.
`default_nettype none
package pde_pkg;

    localparam int unsigned COEF_W  = 32;
    localparam int unsigned DEG_W   = 8;
    localparam int unsigned POINT_W = 32;
    localparam int unsigned ORDER_W = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned IN_W    = COEF_W + DEG_W + POINT_W + ORDER_W;

    localparam int unsigned DEGREE_MAX_DEF = 255;
    localparam int unsigned ORDER_MAX_DEF  = 255;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_NONE  = 3'd0;
    localparam t_cmd CMD_LOAD  = 3'd1;
    localparam t_cmd CMD_FACT  = 3'd2;
    localparam t_cmd CMD_POW_R = 3'd3;
    localparam t_cmd CMD_POW_B = 3'd4;
    localparam t_cmd CMD_TERM  = 3'd5;
    localparam t_cmd CMD_ACC   = 3'd6;
    localparam t_cmd CMD_EMIT  = 3'd7;

    typedef struct packed {
        logic n_gt_d;
        logic fact_done;
        logic e_zero;
        logic e_lsb;
        logic last;
        logic mul_busy;
        logic mul_done;
    } t_status;

endpackage
`default_nettype wire

/* rtl/pde_mul.sv */
// 64x64 multiplier modulo 2^64 built from one 32x32 multiplier used in turn for three partial products.
`default_nettype none
module pde_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_p
);
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_p;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;

    // step 0: lo*lo, step 1: lo*hi, step 2: hi*lo (upper halves only)
    assign op_a = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
    assign op_b = (r_step == 2'd1) ? r_b[63:32] : r_b[31:0];
    assign prod = {32'b0, op_a} * {32'b0, op_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (r_step == 2'd0) begin
                r_p <= prod;
            end else begin
                r_p[63:32] <= r_p[63:32] + prod[31:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

/* rtl/pde_datapath.sv */
// Term registers, shared multiplier, running sum and output register.
`default_nettype none
module pde_datapath #(
    parameter int unsigned DEGREE_MAX = pde_pkg::DEGREE_MAX_DEF,
    parameter int unsigned ORDER_MAX  = pde_pkg::ORDER_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pde_pkg::t_cmd                 i_cmd,
    input  wire logic [pde_pkg::IN_W-1:0]      i_in_data,
    input  wire logic                          i_in_last,
    output pde_pkg::t_status                   o_status,
    output logic [pde_pkg::VALUE_W-1:0]        o_out_data
);
    import pde_pkg::*;

    logic [VALUE_W-1:0] r_c;
    logic [VALUE_W-1:0] r_base;
    logic [VALUE_W-1:0] r_r;
    logic [VALUE_W-1:0] r_term;
    logic [VALUE_W-1:0] r_sum;
    logic [VALUE_W-1:0] r_out;
    logic [DEG_W-1:0]   r_d;
    logic [ORDER_W-1:0] r_n;
    logic [ORDER_W-1:0] r_i;
    logic [DEG_W-1:0]   r_e;
    logic               r_last;
    t_cmd               r_dest;

    logic [COEF_W-1:0]  in_coef;
    logic [DEG_W-1:0]   in_deg;
    logic [POINT_W-1:0] in_point;
    logic [ORDER_W-1:0] in_order;
    logic [DEG_W-1:0]   deg_cl;
    logic [ORDER_W-1:0] ord_cl;

    logic               mul_start;
    logic [VALUE_W-1:0] mul_a;
    logic [VALUE_W-1:0] mul_b;
    logic               mul_busy;
    logic               mul_done;
    logic [VALUE_W-1:0] mul_p;

    assign in_coef  = i_in_data[COEF_W-1:0];
    assign in_deg   = i_in_data[COEF_W+DEG_W-1:COEF_W];
    assign in_point = i_in_data[COEF_W+DEG_W+POINT_W-1:COEF_W+DEG_W];
    assign in_order = i_in_data[IN_W-1:COEF_W+DEG_W+POINT_W];

    // clamp value only taken when the limit is below the field's range
    assign deg_cl = ({24'b0, in_deg} > 32'(DEGREE_MAX)) ? DEG_W'(DEGREE_MAX) : in_deg;
    assign ord_cl = ({24'b0, in_order} > 32'(ORDER_MAX)) ? ORDER_W'(ORDER_MAX) : in_order;

    always_comb begin
        mul_start = 1'b1;
        mul_a     = r_c;
        mul_b     = r_r;
        unique case (i_cmd)
            CMD_FACT: begin
                mul_a = r_c;
                mul_b = {{(VALUE_W-DEG_W){1'b0}}, r_d - DEG_W'(r_i)};
            end
            CMD_POW_R: begin
                mul_a = r_r;
                mul_b = r_base;
            end
            CMD_POW_B: begin
                mul_a = r_base;
                mul_b = r_base;
            end
            CMD_TERM: begin
                mul_a = r_c;
                mul_b = r_r;
            end
            default: mul_start = 1'b0;
        endcase
    end

    pde_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd == CMD_ACC) begin
            r_sum <= r_sum + r_term;
        end else if (i_cmd == CMD_EMIT) begin
            r_sum <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_c    <= {{(VALUE_W-COEF_W){in_coef[COEF_W-1]}}, in_coef};
            r_base <= {{(VALUE_W-POINT_W){in_point[POINT_W-1]}}, in_point};
            r_r    <= {{(VALUE_W-1){1'b0}}, 1'b1};
            r_term <= '0;
            r_d    <= deg_cl;
            r_n    <= ord_cl;
            r_e    <= deg_cl - DEG_W'(ord_cl);
            r_i    <= '0;
            r_last <= i_in_last;
        end
        if (mul_start) begin
            r_dest <= i_cmd;
        end
        if (i_cmd == CMD_FACT) begin
            r_i <= r_i + ORDER_W'(1);
        end
        if (mul_done) begin
            unique case (r_dest)
                CMD_FACT:  r_c <= mul_p;
                CMD_POW_R: r_r <= mul_p;
                CMD_POW_B: begin
                    r_base <= mul_p;
                    r_e    <= r_e >> 1;
                end
                CMD_TERM:  r_term <= mul_p;
                default: ;
            endcase
        end
        if (i_cmd == CMD_EMIT) begin
            r_out <= r_sum;
        end
    end

    assign o_status.n_gt_d    = r_n > ORDER_W'(r_d);
    assign o_status.fact_done = r_i == r_n;
    assign o_status.e_zero    = r_e == '0;
    assign o_status.e_lsb     = r_e[0];
    assign o_status.last      = r_last;
    assign o_status.mul_busy  = mul_busy;
    assign o_status.mul_done  = mul_done;
    assign o_out_data         = r_out;
endmodule
`default_nettype wire

/* rtl/pde_ctrl.sv */
// Sequencer: load, factor loop, square-and-multiply loop, accumulate, emit.
`default_nettype none
module pde_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire pde_pkg::t_status i_status,
    output pde_pkg::t_cmd         o_cmd
);
    import pde_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_FACT   = 4'd2;
    localparam logic [3:0] ST_WAIT_F = 4'd3;
    localparam logic [3:0] ST_POW    = 4'd4;
    localparam logic [3:0] ST_WAIT_R = 4'd5;
    localparam logic [3:0] ST_POW_B  = 4'd6;
    localparam logic [3:0] ST_WAIT_B = 4'd7;
    localparam logic [3:0] ST_WAIT_T = 4'd8;
    localparam logic [3:0] ST_ACC    = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd     = CMD_LOAD;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // order above degree: term stays zero
                n_state = i_status.n_gt_d ? ST_ACC : ST_FACT;
            end
            ST_FACT: begin
                if (i_status.fact_done) begin
                    n_state = ST_POW;
                end else begin
                    cmd     = CMD_FACT;
                    n_state = ST_WAIT_F;
                end
            end
            ST_WAIT_F: if (i_status.mul_done) n_state = ST_FACT;
            ST_POW: begin
                if (i_status.e_zero) begin
                    cmd     = CMD_TERM;
                    n_state = ST_WAIT_T;
                end else if (i_status.e_lsb) begin
                    cmd     = CMD_POW_R;
                    n_state = ST_WAIT_R;
                end else begin
                    cmd     = CMD_POW_B;
                    n_state = ST_WAIT_B;
                end
            end
            ST_WAIT_R: if (i_status.mul_done) n_state = ST_POW_B;
            ST_POW_B: begin
                cmd     = CMD_POW_B;
                n_state = ST_WAIT_B;
            end
            ST_WAIT_B: if (i_status.mul_done) n_state = ST_POW;
            ST_WAIT_T: if (i_status.mul_done) n_state = ST_ACC;
            ST_ACC: begin
                cmd     = CMD_ACC;
                n_state = i_status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    cmd     = CMD_EMIT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (cmd == CMD_EMIT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTHESIS
    a_ready_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_status.mul_busy)
        else $error("input ready while multiplier busy");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == CMD_EMIT) |-> (!r_out_valid || i_out_ready))
        else $error("emit would overwrite pending result");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == CMD_EMIT) |=> r_out_valid)
        else $error("emit did not raise output valid");
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == CMD_FACT || cmd == CMD_POW_R || cmd == CMD_POW_B || cmd == CMD_TERM)
        |-> !i_status.mul_busy)
        else $error("multiply issued while busy");
`endif
endmodule
`default_nettype wire

/* rtl/poly_derivative_eval.sv */
// Top level: n-th derivative of a streamed sparse polynomial evaluated at a point.
// Usage:
//   Slave channel: one polynomial term per transfer. tlast marks the final term.
//   Master channel: one 64-bit wrapped sum per polynomial, after its last term.
//   Each term scales coef by degree*(degree-1)*... over order factors, raises
//   point to degree-order, and adds the product into a running 64-bit sum.
// Timing:
//   Every 64-bit product runs on one shared 32x32 multiplier as three partial
//   products, one after another. Order above degree skips the factor and power
//   loops. The multiplier is the limiting unit; one term is in work at a time.
// Reset: synchronous active low; clears the running sum and the output valid flag.
// Stall: a finished sum waits in the output register; the next polynomial's
//   terms are still taken, and only its own final result waits for the register,
//   holding off the input until the register frees up.
`default_nettype none
module poly_derivative_eval #(
    parameter int unsigned DEGREE_MAX = pde_pkg::DEGREE_MAX_DEF,
    parameter int unsigned ORDER_MAX  = pde_pkg::ORDER_MAX_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // coef[31:0], degree[39:32], point[71:40], order[79:72]
    input  wire logic [pde_pkg::IN_W-1:0] i_s_axis_tdata,
    input  wire logic                     i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // value[63:0]
    output logic [pde_pkg::VALUE_W-1:0]   o_m_axis_tdata
);
    import pde_pkg::*;

    t_cmd    cmd;
    t_status status;

    pde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pde_datapath #(
        .DEGREE_MAX (DEGREE_MAX),
        .ORDER_MAX  (ORDER_MAX)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_s_axis_tdata),
        .i_in_last  (i_s_axis_tlast),
        .o_status   (status),
        .o_out_data (o_m_axis_tdata)
    );
endmodule
`default_nettype wire
